// ===== hw/rtl/wdrc_pkg.sv =====
// package for the weighted degenerate residue counter
// holds request/response types, opcodes, alphabet constants and degeneracy tables
// no dependencies
package wdrc_pkg;

    // store size default and field widths
    localparam int WDRC_NUM_COUNTERS = 20;
    localparam int WDRC_CNT_W        = 40;
    localparam int WDRC_SHARE_W      = 24;
    localparam int WDRC_WEIGHT_W     = 16;
    localparam int WDRC_SYM_W        = 5;
    localparam int WDRC_CANON_MAX    = 20;

    // operation codes
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // alphabet modes
    localparam logic MODE_AMINO   = 1'b0;
    localparam logic MODE_NUCLEIC = 1'b1;

    // alphabet sizes
    localparam logic [WDRC_SYM_W-1:0] AA_CANON = 5'd20;
    localparam logic [WDRC_SYM_W-1:0] AA_CODES = 5'd24;
    localparam logic [WDRC_SYM_W-1:0] NT_CANON = 5'd4;
    localparam logic [WDRC_SYM_W-1:0] NT_CODES = 5'd17;

    // counter saturation value
    localparam logic [WDRC_CNT_W-1:0] CNT_MAX = {WDRC_CNT_W{1'b1}};

    // input request
    typedef struct packed {
        logic [1:0]               operation;
        logic [WDRC_SYM_W-1:0]    symbol_index;
        logic [WDRC_WEIGHT_W-1:0] weight;
        logic [WDRC_SYM_W-1:0]    counter_index;
    } t_in_req;

    // result
    typedef struct packed {
        logic                  status;
        logic [WDRC_CNT_W-1:0] read_value;
    } t_out_rsp;

    // member set of a code, one bit per canonical symbol
    function automatic logic [WDRC_CANON_MAX-1:0] f_member_mask(
        input logic                  mode,
        input logic [WDRC_SYM_W-1:0] sym
    );
        logic [WDRC_CANON_MAX-1:0] m;
        m = '0;
        if (mode == MODE_NUCLEIC) begin
            unique case (sym)
                5'd0:  m = 20'h00001;  // A
                5'd1:  m = 20'h00002;  // C
                5'd2:  m = 20'h00004;  // G
                5'd3:  m = 20'h00008;  // T
                5'd4:  m = 20'h00008;  // U -> T
                5'd5:  m = 20'h0000F;  // N
                5'd6:  m = 20'h00005;  // R
                5'd7:  m = 20'h0000A;  // Y
                5'd8:  m = 20'h00003;  // M
                5'd9:  m = 20'h0000C;  // K
                5'd10: m = 20'h00006;  // S
                5'd11: m = 20'h00009;  // W
                5'd12: m = 20'h0000B;  // H
                5'd13: m = 20'h0000E;  // B
                5'd14: m = 20'h00007;  // V
                5'd15: m = 20'h0000D;  // D
                5'd16: m = 20'h0000F;  // X
                default: m = '0;
            endcase
        end else begin
            priority if (sym < AA_CANON) begin
                m = WDRC_CANON_MAX'(1) << sym;
            end else if (sym == 5'd20) begin
                m = 20'h08000;           // U -> S
            end else if (sym == 5'd21) begin
                m = 20'h00804;           // B -> N, D
            end else if (sym == 5'd22) begin
                m = 20'h02008;           // Z -> Q, E
            end else if (sym == 5'd23) begin
                m = 20'hFFFFF;           // X -> all
            end else begin
                m = '0;
            end
        end
        return m;
    endfunction

    // number of members in a set
    function automatic logic [WDRC_SYM_W-1:0] f_member_count(
        input logic [WDRC_CANON_MAX-1:0] m
    );
        logic [WDRC_SYM_W-1:0] n;
        n = '0;
        for (int i = 0; i < WDRC_CANON_MAX; i++) begin
            n = n + WDRC_SYM_W'(m[i]);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/weighted_degenerate_residue_counter.sv =====
// top level: request decode, sequencer, divider and counter bank
// depends on wdrc_pkg, wdrc_div, wdrc_bank
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_data (alphabet mode)
//  in      | i_in_valid  | o_in_ready  | i_in  (t_in_req)
//  out     | o_out_valid | i_out_ready | o_out (t_out_rsp)
//
// a count request goes through decode, the serial divider for the share, then
// the shared saturating adder at one counter per cycle over the mode's canonical
// size (20 or 4), then output and idle. read, clear and rejected requests go
// from decode straight to output.
// one request at a time; o_in_ready is high only while idle, and a result
// waits in the output register until taken. reset clears all counters at once,
// no sweep. cfg writes are always accepted.
module weighted_degenerate_residue_counter
    import wdrc_pkg::*;
#(
    parameter int NUM_COUNTERS = WDRC_NUM_COUNTERS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_rsp o_out
);

    localparam int AW = $clog2(NUM_COUNTERS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_mode;
    t_in_req                   r_req;
    t_out_rsp                  r_out, n_out;
    logic [WDRC_CANON_MAX-1:0] r_mask, n_mask;
    logic [WDRC_SYM_W-1:0]     r_idx, n_idx;
    logic [WDRC_SHARE_W-1:0]   r_share;

    logic [WDRC_SYM_W-1:0]     canon;
    logic [WDRC_SYM_W-1:0]     codes;
    logic                      div_start;
    logic                      div_done;
    logic [WDRC_SHARE_W-1:0]   div_quo;
    logic                      bank_clear;
    logic                      bank_wr;
    logic [AW-1:0]             bank_addr;
    logic [WDRC_CNT_W-1:0]     bank_rd;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

    // alphabet sizes for current mode
    assign canon = (r_mode == MODE_NUCLEIC) ? NT_CANON : AA_CANON;
    assign codes = (r_mode == MODE_NUCLEIC) ? NT_CODES : AA_CODES;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_AMINO;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_out      = r_out;
        n_mask     = r_mask;
        n_idx      = r_idx;
        div_start  = 1'b0;
        bank_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out   = '0;
                n_state = S_OUT;
                unique case (r_req.operation)
                    OP_COUNT: begin
                        if (r_req.symbol_index < codes) begin
                            n_mask    = f_member_mask(r_mode, r_req.symbol_index);
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_out.status = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (r_req.counter_index < canon &&
                            int'(r_req.counter_index) < NUM_COUNTERS) begin
                            n_out.read_value = bank_rd;
                        end else begin
                            n_out.status = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        bank_clear = 1'b1;
                    end
                    default: begin
                        n_out.status = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                n_idx = '0;
                if (div_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_idx = r_idx + WDRC_SYM_W'(1);
                if (r_idx == canon - WDRC_SYM_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // bank access: walk index while adding, read index otherwise
    assign bank_wr   = (r_state == S_ADD) && r_mask[r_idx] &&
                       (int'(r_idx) < NUM_COUNTERS);
    assign bank_addr = (r_state == S_ADD) ? r_idx[AW-1:0] : r_req.counter_index[AW-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in;
        end
        if (div_done) begin
            r_share <= div_quo;
        end
        r_out  <= n_out;
        r_mask <= n_mask;
    end

    // share = weight * 256 / member count
    wdrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_req.weight, 8'd0}),
        .i_divisor  (f_member_count(n_mask)),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // counter store
    wdrc_bank #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .AW           (AW)
    ) u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (bank_clear),
        .i_wr      (bank_wr),
        .i_addr    (bank_addr),
        .i_share   (r_share),
        .o_rd_data (bank_rd)
    );

endmodule

// ===== hw/rtl/wdrc_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on wdrc_pkg for the share and symbol widths
module wdrc_div
    import wdrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [WDRC_SHARE_W-1:0] i_dividend,
    input  logic [WDRC_SYM_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [WDRC_SHARE_W-1:0] o_quotient
);

    localparam int CW = $clog2(WDRC_SHARE_W);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [WDRC_SYM_W-1:0]   r_rem;
    logic [WDRC_SYM_W-1:0]   r_div;
    logic [WDRC_SHARE_W-1:0] r_quo;

    logic [WDRC_SYM_W:0]     trial;
    logic                    q_bit;
    logic [WDRC_SYM_W-1:0]   n_rem;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_quo[WDRC_SHARE_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        if (q_bit) begin
            n_rem = WDRC_SYM_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[WDRC_SYM_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(WDRC_SHARE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[WDRC_SHARE_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/wdrc_bank.sv =====
// counter bank with one saturating accumulate unit and one read port
// depends on wdrc_pkg for counter and share widths
module wdrc_bank
    import wdrc_pkg::*;
#(
    parameter int NUM_COUNTERS = WDRC_NUM_COUNTERS,
    parameter int AW           = $clog2(NUM_COUNTERS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_wr,
    input  logic [AW-1:0]           i_addr,
    input  logic [WDRC_SHARE_W-1:0] i_share,
    output logic [WDRC_CNT_W-1:0]   o_rd_data
);

    logic [WDRC_CNT_W-1:0] r_cnt [NUM_COUNTERS];
    logic [WDRC_CNT_W:0]   sum;
    logic [WDRC_CNT_W-1:0] n_cnt;

    // selected counter
    assign o_rd_data = r_cnt[i_addr];

    // saturating add
    always_comb begin
        sum   = {1'b0, o_rd_data} + (WDRC_CNT_W + 1)'(i_share);
        n_cnt = sum[WDRC_CNT_W] ? CNT_MAX : sum[WDRC_CNT_W-1:0];
    end

    // store update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_wr) begin
            r_cnt[i_addr] <= n_cnt;
        end
    end

endmodule

// ===== test/weighted_degenerate_residue_counter_test.sv =====
// self-checking bench for weighted_degenerate_residue_counter: directed and random requests
// with random idling on both channels, checked against a bit-true predictor in this module
// depends on wdrc_pkg and the block's rtl
module weighted_degenerate_residue_counter_test
    import wdrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = WDRC_NUM_COUNTERS;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int PHASE_ITEMS = 255;
    localparam int RX_HOLD_AT = 700;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    // clock, reset and block inputs, all known from time zero
    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     out_ready = 1'b0;
    logic     o_cfg_ready;
    logic     o_in_ready;
    logic     o_out_valid;
    t_out_rsp o_out;

    // request queue, expected responses and bookkeeping
    t_in_req  req_pending[$];
    t_out_rsp rsp_expect[$];
    int       n_pushed = 0;
    int       n_checked = 0;
    int       n_errors = 0;
    int       idle_pct = 33;
    int       rx_hold_left = 0;
    bit       rx_hold_done = 1'b0;

    // predictor state: alphabet mode and counter bank
    logic                  cur_mode = MODE_AMINO;
    logic [WDRC_CNT_W-1:0] tally [STORE_DEPTH];

    weighted_degenerate_residue_counter #(
        .NUM_COUNTERS(STORE_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    // canonical members of a residue code, one bit per counter
    function automatic logic [WDRC_CANON_MAX-1:0] code_members(input logic mode,
                                                               input logic [4:0] code);
        logic [3:0] nt;
        if (mode == MODE_NUCLEIC) begin
            // bit order A C G T -> 0 1 2 3
            case (code)
                5'd0:           nt = 4'b0001;
                5'd1:           nt = 4'b0010;
                5'd2:           nt = 4'b0100;
                5'd3, 5'd4:     nt = 4'b1000;
                5'd5, 5'd16:    nt = 4'b1111;
                5'd6:           nt = 4'b0101;
                5'd7:           nt = 4'b1010;
                5'd8:           nt = 4'b0011;
                5'd9:           nt = 4'b1100;
                5'd10:          nt = 4'b0110;
                5'd11:          nt = 4'b1001;
                5'd12:          nt = 4'b1011;
                5'd13:          nt = 4'b1110;
                5'd14:          nt = 4'b0111;
                5'd15:          nt = 4'b1101;
                default:        nt = 4'b0000;
            endcase
            return {{(WDRC_CANON_MAX-4){1'b0}}, nt};
        end
        // amino: canonical codes map to themselves, then U, B, Z, X
        if (code < 5'd20) return 20'd1 << code;
        case (code)
            5'd20:   return 20'd1 << 15;
            5'd21:   return (20'd1 << 11) | (20'd1 << 2);
            5'd22:   return (20'd1 << 13) | (20'd1 << 3);
            5'd23:   return {WDRC_CANON_MAX{1'b1}};
            default: return '0;
        endcase
    endfunction

    // apply one request to the predicted bank and return its response
    function automatic t_out_rsp apply_request(input t_in_req req);
        t_out_rsp                  rsp;
        logic [WDRC_CANON_MAX-1:0] members;
        logic [WDRC_SHARE_W-1:0]   share;
        logic [WDRC_CNT_W:0]       sum;
        int                        n_canon;
        int                        n_codes;
        int                        n_members;
        rsp = '0;
        n_canon = (cur_mode == MODE_NUCLEIC) ? int'(NT_CANON) : int'(AA_CANON);
        n_codes = (cur_mode == MODE_NUCLEIC) ? int'(NT_CODES) : int'(AA_CODES);
        case (req.operation)
            OP_COUNT: begin
                if (int'(req.symbol_index) >= n_codes) begin
                    rsp.status = 1'b1;
                end else begin
                    members = code_members(cur_mode, req.symbol_index);
                    n_members = $countones(members);
                    share = WDRC_SHARE_W'({req.weight, 8'h00} / n_members);
                    for (int x = 0; x < n_canon && x < STORE_DEPTH; x++) begin
                        if (members[x]) begin
                            sum = {1'b0, tally[x]} + (WDRC_CNT_W + 1)'(share);
                            tally[x] = sum[WDRC_CNT_W] ? CNT_MAX : sum[WDRC_CNT_W-1:0];
                        end
                    end
                end
            end
            OP_READ: begin
                if (int'(req.counter_index) >= n_canon
                        || int'(req.counter_index) >= STORE_DEPTH) begin
                    rsp.status = 1'b1;
                end else begin
                    rsp.read_value = tally[req.counter_index];
                end
            end
            OP_CLEAR: begin
                for (int x = 0; x < STORE_DEPTH; x++) tally[x] = '0;
            end
            default: begin
                rsp.status = 1'b1;
            end
        endcase
        return rsp;
    endfunction

    // request driver: predict on acceptance, then offer the next pending request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            for (int x = 0; x < STORE_DEPTH; x++) tally[x] = '0;
        end else begin
            if (in_valid && o_in_ready) begin
                rsp_expect.push_back(apply_request(in_req));
            end
            if (!in_valid || o_in_ready) begin
                if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_req   <= req_pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor: compare with the oldest expectation, stall at random
    always @(posedge i_clk) begin
        t_out_rsp exp_rsp;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_checked++;
                if (rsp_expect.size() == 0) begin
                    $display("%0t: unexpected response status %0d value %h", $time,
                             o_out.status, o_out.read_value);
                    n_errors++;
                end else begin
                    exp_rsp = rsp_expect.pop_front();
                    if (o_out.status !== exp_rsp.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_rsp.status, o_out.status);
                        n_errors++;
                    end
                    if (o_out.read_value !== exp_rsp.read_value) begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 exp_rsp.read_value, o_out.read_value);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block backs up into the request channel
            if (!rx_hold_done && n_checked >= RX_HOLD_AT) begin
                rx_hold_left = RX_HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic queue_req(input logic [1:0] op, input logic [4:0] sym,
                             input logic [15:0] wt, input logic [4:0] ci);
        t_in_req req;
        req.operation     = op;
        req.symbol_index  = sym;
        req.weight        = wt;
        req.counter_index = ci;
        req_pending.push_back(req);
        n_pushed++;
    endtask

    task automatic queue_random(input logic mode);
        int          sel;
        int          n_canon;
        int          n_codes;
        logic [1:0]  op;
        logic [4:0]  sym;
        logic [15:0] wt;
        logic [4:0]  ci;
        n_canon = (mode == MODE_NUCLEIC) ? int'(NT_CANON) : int'(AA_CANON);
        n_codes = (mode == MODE_NUCLEIC) ? int'(NT_CODES) : int'(AA_CODES);
        sel = $urandom_range(99);
        if (sel < 64) op = OP_COUNT;
        else if (sel < 90) op = OP_READ;
        else if (sel < 93) op = OP_CLEAR;
        else op = OP_UNKNOWN;
        sym = ($urandom_range(99) < 85) ? 5'($urandom_range(n_codes - 1))
                                        : 5'($urandom_range(31));
        sel = $urandom_range(99);
        if (sel < 10) wt = 16'hFFFF;
        else if (sel < 15) wt = 16'h0000;
        else wt = 16'($urandom);
        ci = ($urandom_range(99) < 85) ? 5'($urandom_range(n_canon - 1))
                                       : 5'($urandom_range(31));
        queue_req(op, sym, wt, ci);
    endtask

    // pause until every queued request has its response back
    task automatic wait_drained;
        while (n_checked < n_pushed) @(posedge i_clk);
    endtask

    // alphabet mode write, only while the block is idle
    task automatic write_mode(input logic mode);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    // main sequence
    initial begin
        logic phase_mode [6];
        phase_mode = '{MODE_AMINO, MODE_NUCLEIC, MODE_AMINO,
                       MODE_NUCLEIC, MODE_AMINO, MODE_NUCLEIC};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // amino alphabet: canonical, degenerate and rejected codes
        write_mode(MODE_AMINO);
        queue_req(OP_COUNT, 5'd0, 16'hFFFF, 5'd0);
        queue_req(OP_COUNT, 5'd19, 16'h0001, 5'd0);
        queue_req(OP_COUNT, 5'd23, 16'hFFFF, 5'd0);
        queue_req(OP_COUNT, 5'd21, 16'h0003, 5'd0);
        queue_req(OP_COUNT, 5'd22, 16'h0101, 5'd0);
        queue_req(OP_COUNT, 5'd20, 16'h8000, 5'd0);
        queue_req(OP_COUNT, 5'd24, 16'hFFFF, 5'd0);
        queue_req(OP_COUNT, 5'd31, 16'h1234, 5'd31);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd0);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd15);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd19);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd20);
        queue_req(OP_READ, 5'd31, 16'hFFFF, 5'd31);
        queue_req(OP_UNKNOWN, 5'd31, 16'hFFFF, 5'd31);
        queue_req(OP_CLEAR, 5'd0, 16'h0000, 5'd0);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd0);
        queue_req(OP_COUNT, 5'd23, 16'hFFFF, 5'd0);
        wait_drained();

        // nucleic alphabet: counters survive the mode change
        write_mode(MODE_NUCLEIC);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd0);
        queue_req(OP_COUNT, 5'd5, 16'h0001, 5'd0);
        queue_req(OP_COUNT, 5'd12, 16'hFFFF, 5'd0);
        queue_req(OP_COUNT, 5'd16, 16'hFFFF, 5'd0);
        queue_req(OP_COUNT, 5'd4, 16'h00FF, 5'd0);
        queue_req(OP_COUNT, 5'd17, 16'hFFFF, 5'd0);
        queue_req(OP_COUNT, 5'd0, 16'h0000, 5'd0);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd3);
        queue_req(OP_READ, 5'd0, 16'h0000, 5'd4);
        wait_drained();

        // random phases, alternating alphabets, one without idling
        for (int p = 0; p < 6; p++) begin
            write_mode(phase_mode[p]);
            idle_pct = (p == 3) ? 0 : 33;
            for (int k = 0; k < PHASE_ITEMS; k++) queue_random(phase_mode[p]);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rsp_expect.size() != 0) begin
            $display("%0t: %0d expected responses never arrived", $time, rsp_expect.size());
        end
        if (n_errors == 0 && rsp_expect.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wdrc_pkg.sv
hw/rtl/wdrc_div.sv
hw/rtl/wdrc_bank.sv
hw/rtl/weighted_degenerate_residue_counter.sv
test/weighted_degenerate_residue_counter_test.sv
